@@ design/atfc_pkg.sv @@
// Shared types, constants and the calibration ROM for the ADC temperature fan controller.
// No dependencies; every other file in the design folder imports this package.
package atfc_pkg;

  localparam int SAMPLE_W        = 10;
  localparam int TEMP_W          = 7;
  localparam int DUTY_W          = 8;
  localparam int ROM_AW          = 7;
  localparam int CAL_ENTRIES     = 76;
  localparam int TABLE_ENTRIES_D = 76;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_CODE = 10'h3FF;
  localparam logic [TEMP_W-1:0]   TARGET_RESET    = 7'd24;
  localparam logic [DUTY_W-1:0]   DUTY_OFF        = 8'h00;
  localparam logic [DUTY_W-1:0]   DUTY_FULL       = 8'hFF;
  localparam logic [DUTY_W-1:0]   DUTY_AT_TARGET  = 8'h9F;
  localparam logic [DUTY_W-1:0]   DUTY_NEAR_HOT   = 8'hBF;
  localparam logic [DUTY_W-1:0]   DUTY_NEAR_COLD  = 8'h5F;
  localparam logic [7:0]          BASE_TEMP       = 8'd15;
  localparam logic [7:0]          BELOW_BASE_TEMP = 8'd14;

  // Entry i is the converter reading for 15+i degrees C.
  localparam logic [SAMPLE_W-1:0] CAL_ROM [0:CAL_ENTRIES-1] = '{
    10'h064, 10'h069, 10'h06E, 10'h073, 10'h078, 10'h07E, 10'h083, 10'h089, 10'h08F, 10'h095,
    10'h09C, 10'h0A2, 10'h0A9, 10'h0B0, 10'h0B7, 10'h0BF, 10'h0C6, 10'h0CE, 10'h0D6, 10'h0DF,
    10'h0E7, 10'h0F0, 10'h0F9, 10'h102, 10'h10C, 10'h116, 10'h120, 10'h12A, 10'h134, 10'h13F,
    10'h14A, 10'h155, 10'h161, 10'h16C, 10'h178, 10'h184, 10'h191, 10'h19D, 10'h1AA, 10'h1B7,
    10'h1C4, 10'h1D2, 10'h1E0, 10'h1ED, 10'h1FB, 10'h20A, 10'h218, 10'h227, 10'h236, 10'h245,
    10'h254, 10'h263, 10'h273, 10'h282, 10'h292, 10'h2A2, 10'h2B2, 10'h2C2, 10'h2D2, 10'h2E2,
    10'h2F3, 10'h303, 10'h314, 10'h324, 10'h335, 10'h346, 10'h357, 10'h367, 10'h378, 10'h389,
    10'h39A, 10'h3AB, 10'h3BC, 10'h3CD, 10'h3DD, 10'h3EE
  };

  // Slots past the calibrated entries read as full scale.
  function automatic logic [SAMPLE_W-1:0] cal_rom(input logic [ROM_AW-1:0] addr);
    logic [SAMPLE_W-1:0] val;
    if (addr < ROM_AW'(CAL_ENTRIES)) begin
      val = CAL_ROM[addr];
    end else begin
      val = FULL_SCALE_CODE;
    end
    return val;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DECIDE
  } atfc_state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic commit;
  } atfc_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic slot_free;
  } atfc_status_t;

endpackage

@@ design/atfc_ctrl.sv @@
// Controller state machine of the ADC temperature fan controller.
// Depends on atfc_pkg; drives the datapath atfc_dp through command and status structs.
module atfc_ctrl
  import atfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  atfc_status_t status,
  output atfc_cmd_t    cmd
);

  atfc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_WALK: begin
        cmd.advance = !status.walk_done;
      end
      ST_DECIDE: begin
        cmd.commit = status.slot_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // A finished walk always moves on to the decision step.
  a_walk_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && status.walk_done |=> state_r == ST_DECIDE)
    else $error("walk end did not reach decision step");

  // A request is taken only from idle, and leads into the walk.
  a_load_to_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_WALK)
    else $error("accepted request did not start a walk");

  // The result is committed only when the output slot can take it.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> status.slot_free)
    else $error("commit while output slot busy");

endmodule

@@ design/atfc_dp.sv @@
// Datapath of the ADC temperature fan controller: sample, walk counter, ROM compare,
// nearest-neighbour pick, duty rules and the output register. Depends on atfc_pkg.
module atfc_dp
  import atfc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic                cfg_wen,
  input  logic [TEMP_W-1:0]   cfg_wdata,
  input  atfc_cmd_t           cmd,
  output atfc_status_t        status,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [TEMP_W-1:0]   temperature,
  output logic [DUTY_W-1:0]   fan_duty,
  output logic                full_scale
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES);

  logic [SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [TEMP_W-1:0]   target_r;
  logic [TEMP_W-1:0]   last_off_r;
  logic [TEMP_W-1:0]   temp_r;
  logic [DUTY_W-1:0]   duty_r;
  logic                fs_r;
  logic                out_valid_r, out_valid_nxt;

  logic [SAMPLE_W-1:0] rom_cur, rom_prev, lo_gap, hi_gap;
  logic                at_end;
  logic [7:0]          temp_sum;
  logic [TEMP_W-1:0]   temp_calc;
  logic [DUTY_W-1:0]   duty_calc;
  logic                near;

  assign rom_cur  = cal_rom(ROM_AW'(idx_r));
  assign rom_prev = cal_rom(ROM_AW'(idx_r - 1'b1));
  assign at_end   = (idx_r == LAST_IDX);

  assign status.walk_done = at_end || (rom_cur >= sample_r);
  assign status.slot_free = !out_valid_r || out_tready;

  assign idx_nxt = cmd.load ? '0 : (cmd.advance ? idx_r + 1'b1 : idx_r);

  // Gaps are only meaningful between the two neighbours that bracket the sample.
  assign lo_gap = sample_r - rom_prev;
  assign hi_gap = rom_cur - sample_r;

  always_comb begin
    priority if (at_end) begin
      temp_sum = 8'(idx_r) + BELOW_BASE_TEMP;
    end else if (idx_r == '0) begin
      temp_sum = BASE_TEMP;
    end else if (lo_gap < hi_gap) begin
      temp_sum = 8'(idx_r) + BELOW_BASE_TEMP;
    end else begin
      temp_sum = 8'(idx_r) + BASE_TEMP;
    end
  end
  assign temp_calc = temp_sum[TEMP_W-1:0];

  assign near = ({1'b0, temp_calc} + 8'd1 == {1'b0, target_r}) ||
                ({1'b0, target_r} + 8'd1 == {1'b0, temp_calc});

  always_comb begin
    priority if (near) begin
      duty_calc = (last_off_r > target_r) ? DUTY_NEAR_HOT : DUTY_NEAR_COLD;
    end else if (temp_calc < target_r) begin
      duty_calc = DUTY_OFF;
    end else if (temp_calc > target_r) begin
      duty_calc = DUTY_FULL;
    end else begin
      duty_calc = DUTY_AT_TARGET;
    end
  end

  assign out_valid_nxt = cmd.commit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= TARGET_RESET;
      last_off_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) target_r <= cfg_wdata;
      if (cmd.commit && (temp_calc != target_r)) last_off_r <= temp_calc;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load) sample_r <= sample_in;
    if (cmd.commit) begin
      temp_r <= temp_calc;
      duty_r <= duty_calc;
      fs_r   <= (sample_r == FULL_SCALE_CODE);
    end
  end

  assign out_tvalid  = out_valid_r;
  assign temperature = temp_r;
  assign fan_duty    = duty_r;
  assign full_scale  = fs_r;

  // The walk counter never passes the last table position.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> idx_r < LAST_IDX)
    else $error("walk counter ran past the table");

  // A committed result shows up as valid in the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("committed result not presented");

  // The walk never advances past an entry that is not below the sample.
  a_advance_below: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !status.walk_done)
    else $error("walk advanced after reaching its stop entry");

endmodule

@@ design/adc_temperature_fan_controller.sv @@
// Top level of the ADC temperature fan controller.
// Depends on atfc_pkg and instantiates atfc_ctrl (state machine) and atfc_dp (datapath).
//
//  Channel  | Direction | Handshake              | Content
//  ---------+-----------+------------------------+-----------------------------------------
//  in_      | in        | in_tvalid / in_tready  | one 10-bit ADC sample per request
//  out_     | out       | out_tvalid / out_tready| temperature, fan duty, full-scale flag
//  cfg_     | in        | cfg_wen                | target temperature, written at once
//
// A request is accepted in idle. The single comparator then steps through the ROM one entry
// per cycle past the calibration entries below the sample (0 to TABLE_ENTRIES of them) and
// stops on the first entry that is not below it or at the end of the table; the decision
// step then commits the result once the output register can take it. Requests are handled
// one at a time: the next request is taken in the cycle after the decision.
// Reset is synchronous and active low; it restores the target to 24 C and clears the
// off-target history. A result held in the output register while out_tready is low does
// not block the next request: only the decision step waits for the register to empty.
module adc_temperature_fan_controller
  import atfc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_D
) (
  input  logic                clk,
  input  logic                rst_n,
  // in_tdata: [9:0] adc_sample, [15:10] zero
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,
  // out_tdata: [6:0] temperature, [14:7] fan_duty, [15] full_scale
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  // Target temperature in degrees C.
  input  logic                cfg_wen,
  input  logic [TEMP_W-1:0]   cfg_wdata
);

  atfc_cmd_t         cmd;
  atfc_status_t      status;
  logic [TEMP_W-1:0] temperature;
  logic [DUTY_W-1:0] fan_duty;
  logic              full_scale;

  // The state machine only sequences load, walk and commit; all values live in the datapath.
  atfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  atfc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_in   (in_tdata[SAMPLE_W-1:0]),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .temperature (temperature),
    .fan_duty    (fan_duty),
    .full_scale  (full_scale)
  );

  assign out_tdata = {full_scale, fan_duty, temperature};

endmodule
